// ----- sv/assert_macros.svh -----
// Assertion macros used by the top level of the record framer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge, ignored while reset is high.
`define CRS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("framer check failed");

// Next-cycle implication checked at every rising edge, ignored while reset is high.
`define CRS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("framer check failed");

`endif

// ----- sv/crs_pkg.sv -----
// Shared constants and types of the checksum record framer.
package crs_pkg;

   localparam int MAX_PACKET_LEN_DEF = 64;
   localparam int MIN_PACKET_LEN     = 3;
   localparam int BYTE_W             = 8;
   localparam int SUM_W              = 16;
   localparam int CNT_W              = 32;
   localparam int PLEN_W             = 7;
   localparam int CSR_IDX_W          = 2;
   localparam int CSR_DATA_W         = 16;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_DELIMITER_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RECORD_DELIMITER = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PACKET_LENGTH    = 2'd2;

   // Control broadcast to every cell of the window row.
   typedef struct packed {
      logic              shift;
      logic              set_tail;
      logic [BYTE_W-1:0] din;
   } crs_cell_ctl_type;

endpackage

// ----- sv/crs_if.sv -----
// Handshake channel interfaces of the record framer.
interface crs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface crs_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  record_byte;
   logic        last;
   logic [15:0] skipped_bytes;
   logic [31:0] skipped_records;
   logic [31:0] total_records;

   modport source (output valid, output record_byte, output last, output skipped_bytes,
                   output skipped_records, output total_records, input ready);
   modport sink   (input valid, input record_byte, input last, input skipped_bytes,
                   input skipped_records, input total_records, output ready);
endinterface

interface crs_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  reg_index;
   logic [15:0] wdata;

   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ----- sv/crs_cell.sv -----
// One byte cell of the window row.
module crs_cell #(
   parameter int INDEX = 0,
   parameter int IW    = 6,
   parameter int LAST  = 63
) (
   input  logic                              clock,
   input  logic                              reset,
   input  crs_pkg::crs_cell_ctl_type         ctl,
   input  logic [IW-1:0]                     tail_idx,
   input  logic [crs_pkg::BYTE_W-1:0]        nbr_byte,
   output logic [crs_pkg::BYTE_W-1:0]        cell_byte
);
   import crs_pkg::*;

   logic              is_tail_ff;
   logic [BYTE_W-1:0] byte_ff;

   // The tail cell takes the new byte; all others take their upper neighbor.
   always_ff @(posedge clock) begin
      if (reset) begin
         is_tail_ff <= (INDEX == LAST);
      end else if (ctl.set_tail) begin
         is_tail_ff <= (tail_idx == IW'(INDEX));
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         byte_ff <= is_tail_ff ? ctl.din : nbr_byte;
      end
   end

   assign cell_byte = byte_ff;

endmodule

// ----- sv/crs_chain.sv -----
// Row of byte cells that holds the window, older bytes toward the head.
module crs_chain #(
   parameter int MAX_PACKET_LEN = crs_pkg::MAX_PACKET_LEN_DEF,
   parameter int IW             = $clog2(MAX_PACKET_LEN)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  crs_pkg::crs_cell_ctl_type  ctl,
   input  logic [IW-1:0]              tail_idx,
   output logic [crs_pkg::BYTE_W-1:0] head_byte,
   output logic [crs_pkg::BYTE_W-1:0] second_byte
);
   import crs_pkg::*;

   logic [BYTE_W-1:0] row [MAX_PACKET_LEN];

   for (genvar i = 0; i < MAX_PACKET_LEN; i++) begin : g_cell
      logic [BYTE_W-1:0] nbr;
      if (i == MAX_PACKET_LEN - 1) begin : g_end
         assign nbr = '0;
      end else begin : g_mid
         assign nbr = row[i+1];
      end
      crs_cell #(
         .INDEX (i),
         .IW    (IW),
         .LAST  (MAX_PACKET_LEN - 1)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .tail_idx  (tail_idx),
         .nbr_byte  (nbr),
         .cell_byte (row[i])
      );
   end

   assign head_byte   = row[0];
   assign second_byte = row[1];

endmodule

// ----- sv/checksum_frame_resync.sv -----
// Top level of the checksum record framer: control, counters and result register.
//
// The framer takes one raw byte per word on req_ch and searches the stream for records of
// packet_length bytes whose last two bytes (little-endian) are either the 16-bit wrapping
// sum of the preceding bytes or, in delimiter mode, the configured delimiter. The window is
// a row of byte cells: each accepted byte enters at the cell that marks the end of the
// record and every cell hands its byte one place toward the head, so a completed record
// has its oldest byte in the head cell. While a record is building, one byte is accepted
// every cycle. When the byte that completes a good record arrives, the record is drained
// out of the head cell one word per cycle while rsp_ch takes it, oldest byte first, and
// req_ch is held off until that drain ends. A result register sits on rsp_ch, and a stalled
// consumer simply stretches the drain. A window that fails the test drops its oldest byte,
// which is counted as skipped. Every result word of a record carries the skipped-byte
// count before it and the saturating skipped-record and total-record counts. Registers may
// be written only while the framer is idle; writing packet_length empties the window but
// keeps the counters. There is no clearing pass after reset: the block is ready in the
// first cycle after reset falls.
`include "assert_macros.svh"

module checksum_frame_resync #(
   parameter int MAX_PACKET_LEN = crs_pkg::MAX_PACKET_LEN_DEF
) (
   input  logic      clock,
   input  logic      reset,
   crs_req_if.sink   req_ch,
   crs_rsp_if.source rsp_ch,
   crs_csr_if.sink   csr_ch
);
   import crs_pkg::*;

   localparam int FW = $clog2(MAX_PACKET_LEN + 1);
   localparam int IW = $clog2(MAX_PACKET_LEN);

   // Configuration registers; the length is kept already clamped.
   logic              mode_ff;
   logic [SUM_W-1:0]  delim_ff;
   logic [FW-1:0]     len_ff,   len_in;

   // Window bookkeeping.
   logic [FW-1:0]     fill_ff,  fill_in;
   logic [SUM_W-1:0]  sum_ff,   sum_in;
   logic [BYTE_W-1:0] prev_ff;

   // Counters.
   logic [SUM_W-1:0]  skip_ff,  skip_in;
   logic [CNT_W-1:0]  skrec_ff, skrec_in;
   logic [CNT_W-1:0]  good_ff,  good_in;
   logic [SUM_W-1:0]  rec_skip_ff, rec_skip_in;

   // Drain of a found record.
   logic [FW-1:0]     drain_ff, drain_in;

   // Result register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff;
   logic              rsp_last_ff;
   logic [SUM_W-1:0]  rsp_skb_ff;
   logic [CNT_W-1:0]  rsp_skr_ff;
   logic [CNT_W-1:0]  rsp_tot_ff;

   logic              req_acc, csr_acc, len_wr;
   logic              draining, step, full_now, good_now, drop_now;
   logic [SUM_W-1:0]  check_word, body_sum;
   logic [FW-1:0]     fill_inc;
   logic [PLEN_W-1:0] plen_raw;
   logic [IW-1:0]     tail_idx;
   logic [BYTE_W-1:0] head_byte, second_byte;
   crs_cell_ctl_type  cell_ctl;

   assign draining = (drain_ff != '0);
   assign req_ch.ready = !draining;
   assign csr_ch.ready = 1'b1;
   assign req_acc = req_ch.valid && req_ch.ready;
   assign csr_acc = csr_ch.valid && csr_ch.ready;
   assign len_wr  = csr_acc && (csr_ch.reg_index == REG_PACKET_LENGTH);

   // A drain step moves one record byte into the result register when it is free.
   assign step = draining && (!rsp_valid_ff || rsp_ch.ready);

   // The window test looks at the window as it stands with the new byte appended:
   // the check word is the new byte over the previous one, and the body sum is the
   // running sum of the earlier bytes less the previous byte.
   assign fill_inc   = fill_ff + FW'(1);
   assign full_now   = (fill_inc == len_ff);
   assign check_word = {req_ch.data_byte, prev_ff};
   assign body_sum   = sum_ff - SUM_W'(prev_ff);
   assign good_now   = mode_ff ? (check_word == delim_ff) : (check_word == body_sum);
   assign drop_now   = req_acc && full_now && !good_now;

   // Clamp the written length into the supported range.
   assign plen_raw = csr_ch.wdata[PLEN_W-1:0];
   always_comb begin
      if (plen_raw < PLEN_W'(MIN_PACKET_LEN)) begin
         len_in = FW'(MIN_PACKET_LEN);
      end else if (plen_raw > PLEN_W'(MAX_PACKET_LEN)) begin
         len_in = FW'(MAX_PACKET_LEN);
      end else begin
         len_in = FW'(plen_raw);
      end
   end
   assign tail_idx = IW'(len_in - FW'(1));

   assign cell_ctl.shift    = req_acc || step;
   assign cell_ctl.set_tail = len_wr;
   assign cell_ctl.din      = req_ch.data_byte;

   crs_chain #(
      .MAX_PACKET_LEN (MAX_PACKET_LEN),
      .IW             (IW)
   ) u_chain (
      .clock       (clock),
      .reset       (reset),
      .ctl         (cell_ctl),
      .tail_idx    (tail_idx),
      .head_byte   (head_byte),
      .second_byte (second_byte)
   );

   // Window, counter and drain updates for an accepted byte, a drain step and a length write.
   always_comb begin
      fill_in     = fill_ff;
      sum_in      = sum_ff;
      skip_in     = skip_ff;
      skrec_in    = skrec_ff;
      good_in     = good_ff;
      rec_skip_in = rec_skip_ff;
      drain_in    = drain_ff;
      if (step) begin
         drain_in = drain_ff - FW'(1);
      end
      if (req_acc) begin
         if (!full_now) begin
            fill_in = fill_inc;
            sum_in  = sum_ff + SUM_W'(req_ch.data_byte);
         end else if (good_now) begin
            // Record found: empty the window and start the drain.
            fill_in     = '0;
            sum_in      = '0;
            drain_in    = len_ff;
            rec_skip_in = skip_ff;
            skip_in     = '0;
            if ((skip_ff != '0) && (skrec_ff != '1)) begin
               skrec_in = skrec_ff + CNT_W'(1);
            end
            if (good_ff != '1) begin
               good_in = good_ff + CNT_W'(1);
            end
         end else begin
            // The oldest byte of the window sits one cell above the head before the shift.
            sum_in = sum_ff + SUM_W'(req_ch.data_byte) - SUM_W'(second_byte);
            if (skip_ff != '1) begin
               skip_in = skip_ff + SUM_W'(1);
            end
         end
      end
      if (len_wr) begin
         fill_in = '0;
         sum_in  = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         delim_ff     <= '0;
         len_ff       <= FW'(MAX_PACKET_LEN);
         fill_ff      <= '0;
         sum_ff       <= '0;
         skip_ff      <= '0;
         skrec_ff     <= '0;
         good_ff      <= '0;
         drain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         skip_ff      <= skip_in;
         skrec_ff     <= skrec_in;
         good_ff      <= good_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_acc) begin
            case (csr_ch.reg_index)
               REG_DELIMITER_MODE:   mode_ff  <= csr_ch.wdata[0];
               REG_RECORD_DELIMITER: delim_ff <= csr_ch.wdata;
               REG_PACKET_LENGTH:    len_ff   <= len_in;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rec_skip_ff <= rec_skip_in;
      if (req_acc) begin
         prev_ff <= req_ch.data_byte;
      end
      if (step) begin
         rsp_byte_ff <= head_byte;
         rsp_last_ff <= (drain_ff == FW'(1));
         rsp_skb_ff  <= rec_skip_ff;
         rsp_skr_ff  <= skrec_ff;
         rsp_tot_ff  <= good_ff;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.record_byte     = rsp_byte_ff;
   assign rsp_ch.last            = rsp_last_ff;
   assign rsp_ch.skipped_bytes   = rsp_skb_ff;
   assign rsp_ch.skipped_records = rsp_skr_ff;
   assign rsp_ch.total_records   = rsp_tot_ff;

   // The window never reaches the record length between words.
   `CRS_ASSERT_IMP(a_fill_below_len, clock, reset, 1'b1, fill_ff < len_ff)
   // A good record starts a drain of exactly one record length.
   `CRS_ASSERT_NXT(a_drain_start, clock, reset, req_acc && full_now && good_now && !len_wr,
                   drain_ff == $past(len_ff))
   // The last drain step ends the drain and leaves a word flagged as last.
   `CRS_ASSERT_NXT(a_drain_end, clock, reset, step && (drain_ff == FW'(1)),
                   !draining && rsp_valid_ff && rsp_last_ff)
   // A dropped byte leaves the window full less one.
   `CRS_ASSERT_NXT(a_drop_keeps_fill, clock, reset, drop_now && !len_wr,
                   fill_ff == $past(fill_ff))

endmodule
